/* hdl/rcfr_pkg.sv */
// rcfr_pkg: shared types and constants for the RC channel frame receiver.
// No dependencies; every other file of the block imports this package.

package rcfr_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 26;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [7:0] SYNC_BYTE = 8'hC8;
    localparam logic [7:0] HDR_LEN   = 8'd24;
    localparam logic [7:0] HDR_TYPE  = 8'h16;

    // Field widths
    localparam int CH_W      = 11;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // Configuration reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 16'd250;
    localparam logic [CH_W-1:0]    THRESH_RESET = 11'd992;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FAILSAFE_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARM_THRESHOLD  = 1'b1;

    // Input mode codes
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    // Command queue depth default
    localparam int QUEUE_DEPTH = 2;

    // Classified command kinds
    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_BYTE,
        CMD_SYNC,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    // Queue to back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

endpackage

/* hdl/rcfr_channels.sv */
// rcfr_channels: valid/ready channel interfaces for the input items and results.
// Depends on rcfr_pkg.

interface rcfr_in_if import rcfr_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    logic       rx_error;

    modport source (output valid, output mode, output rx_byte, output rx_error, input ready);
    modport sink   (input valid, input mode, input rx_byte, input rx_error, output ready);
endinterface

interface rcfr_out_if import rcfr_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] throttle;
    logic            armed;
    logic            failsafe;
    logic            frame_accepted;

    modport source (output valid, output throttle, output armed, output failsafe,
                    output frame_accepted, input ready);
    modport sink   (input valid, input throttle, input armed, input failsafe,
                    input frame_accepted, output ready);
endinterface

/* hdl/rcfr_front.sv */
// rcfr_front: takes input transfers and classifies them into queue commands.
// Depends on rcfr_pkg.

module rcfr_front import rcfr_pkg::*;
(
    input  logic       valid,
    output logic       ready,
    input  logic       mode,
    input  logic [7:0] rx_byte,
    input  logic       rx_error,
    input  logic       q_full,
    output logic       push,
    output cmd_t       cmd
);

    // Handshake: take an item whenever the queue has room
    assign ready = !q_full;
    assign push  = valid && !q_full;

    // Classify: tick, sync byte, plain byte, or errored byte (no-op)
    always_comb
    begin
        cmd.data = rx_byte;
        unique case (mode)
            MODE_TICK: cmd.kind = CMD_TICK;
            MODE_BYTE:
            begin
                if (rx_error)
                    cmd.kind = CMD_NOP;
                else if (rx_byte == SYNC_BYTE)
                    cmd.kind = CMD_SYNC;
                else
                    cmd.kind = CMD_BYTE;
            end
            default: cmd.kind = CMD_NOP;
        endcase
    end

endmodule

/* hdl/rcfr_queue.sv */
// rcfr_queue: short first-word-fall-through command queue between front and back.
// Depends on rcfr_pkg.

module rcfr_queue import rcfr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output logic    full,
    output q_head_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FULL_CNT);
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

/* hdl/rcfr_back.sv */
// rcfr_back: executes queued commands on the frame state and drives the result register.
// Depends on rcfr_pkg.

module rcfr_back import rcfr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  q_head_t              head,
    output logic                 pop,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 res_valid,
    input  logic                 res_ready,
    output logic [CH_W-1:0]      res_throttle,
    output logic                 res_armed,
    output logic                 res_failsafe,
    output logic                 res_frame_accepted
);

    localparam logic [IDX_W-1:0] FRAME_LEN = IDX_W'(FRAME_BYTES);

    // Configuration
    logic [LIMIT_W-1:0] limit_reg;
    logic [CH_W-1:0]    thresh_reg;

    // Frame state
    logic [7:0]         store_reg [FRAME_BYTES];
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [LIMIT_W-1:0] elapsed_reg, elapsed_next;
    logic [CH_W-1:0]    throttle_reg, throttle_next;
    logic               armed_reg, armed_next;
    logic               failsafe_reg, failsafe_next;

    // Result register
    logic               res_valid_reg, res_valid_next;
    logic               res_acc_reg;

    logic               is_byte;
    logic [IDX_W-1:0]   idx_base;
    logic [IDX_W-1:0]   idx_inc;
    logic               frame_done;
    logic               header_ok;
    logic               accept_next;
    logic [CH_W-1:0]    ch0;
    logic [CH_W-1:0]    ch4;
    logic [LIMIT_W-1:0] elapsed_inc;

    // Take a command whenever the result slot is free or being drained
    assign pop = head.valid && (!res_valid_reg || res_ready);

    // Byte path: index restart, store position, frame completion
    assign is_byte    = (head.cmd.kind == CMD_BYTE) || (head.cmd.kind == CMD_SYNC);
    assign idx_base   = ((head.cmd.kind == CMD_SYNC) || (idx_reg >= FRAME_LEN)) ? '0 : idx_reg;
    assign idx_inc    = idx_base + 1'b1;
    assign frame_done = (idx_inc == FRAME_LEN);
    assign header_ok  = (store_reg[0] == SYNC_BYTE) && (store_reg[1] == HDR_LEN) &&
                        (store_reg[2] == HDR_TYPE);

    // Channel unpack from the stored payload
    assign ch0 = {store_reg[4][2:0], store_reg[3]};
    assign ch4 = {store_reg[9][6:0], store_reg[8][7:4]};

    // Saturating millisecond count
    assign elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;

    // Command execution
    always_comb
    begin
        idx_next      = idx_reg;
        elapsed_next  = elapsed_reg;
        throttle_next = throttle_reg;
        armed_next    = armed_reg;
        failsafe_next = failsafe_reg;
        accept_next   = 1'b0;
        if (pop)
        begin
            unique case (head.cmd.kind)
                CMD_BYTE, CMD_SYNC:
                begin
                    idx_next = frame_done ? '0 : idx_inc;
                    if (frame_done && header_ok)
                    begin
                        accept_next   = 1'b1;
                        throttle_next = ch0;
                        armed_next    = (ch4 > thresh_reg);
                        failsafe_next = 1'b0;
                        elapsed_next  = '0;
                    end
                end
                CMD_TICK:
                begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > limit_reg)
                    begin
                        throttle_next = '0;
                        armed_next    = 1'b0;
                        failsafe_next = 1'b1;
                    end
                end
                CMD_NOP: ;
                default: ;
            endcase
        end
    end

    // Result slot handshake
    always_comb
    begin
        if (pop)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            thresh_reg    <= THRESH_RESET;
            idx_reg       <= '0;
            elapsed_reg   <= '0;
            throttle_reg  <= '0;
            armed_reg     <= 1'b0;
            failsafe_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FAILSAFE_LIMIT: limit_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_ARM_THRESHOLD:  thresh_reg <= cfg_data[CH_W-1:0];
                    default: ;
                endcase
            end
            idx_reg       <= idx_next;
            elapsed_reg   <= elapsed_next;
            throttle_reg  <= throttle_next;
            armed_reg     <= armed_next;
            failsafe_reg  <= failsafe_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Frame store and result flag, no reset needed
    always_ff @(posedge clk)
    begin
        if (pop && is_byte)
            store_reg[idx_base] <= head.cmd.data;
        if (pop)
            res_acc_reg <= accept_next;
    end

    assign res_valid          = res_valid_reg;
    assign res_throttle       = throttle_reg;
    assign res_armed          = armed_reg;
    assign res_failsafe       = failsafe_reg;
    assign res_frame_accepted = res_acc_reg;

endmodule

/* hdl/rc_channel_frame_receiver_top.sv */
// rc_channel_frame_receiver_top: top level of the RC channel frame receiver.
// Depends on rcfr_pkg, rcfr_channels, rcfr_front, rcfr_queue and rcfr_back.

// Each input transfer is a serial byte or a 1 ms tick and produces exactly one
// result transfer with throttle, armed, failsafe and frame_accepted as they
// stand after that item. The block takes one item per clock while the result
// side keeps up. The edge that takes an item writes it into the command queue;
// the edge that pops it runs the state update and loads the result register,
// which offers the result. The back end's state update, run once per popped
// command, sets that rate. When the result side stalls, the result register
// and the command queue (QUEUE_DEPTH entries) absorb items before input ready
// drops. Once the stall ends, input ready returns when the first pop has
// lowered the queue count. Configuration writes take effect at the next edge
// and belong in idle periods.

module rc_channel_frame_receiver_top import rcfr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    rcfr_in_if.sink              in_ch,
    rcfr_out_if.source           out_ch,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic    q_full;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    q_head_t head;

    // Front end: handshake and classification
    rcfr_front u_front (
        .valid    (in_ch.valid),
        .ready    (in_ch.ready),
        .mode     (in_ch.mode),
        .rx_byte  (in_ch.rx_byte),
        .rx_error (in_ch.rx_error),
        .q_full   (q_full),
        .push     (push),
        .cmd      (push_cmd)
    );

    // Command queue
    rcfr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    // Back end: frame state and results
    rcfr_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head               (head),
        .pop                (pop),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .res_valid          (out_ch.valid),
        .res_ready          (out_ch.ready),
        .res_throttle       (out_ch.throttle),
        .res_armed          (out_ch.armed),
        .res_failsafe       (out_ch.failsafe),
        .res_frame_accepted (out_ch.frame_accepted)
    );

endmodule

/* hdl/rcfr_checker.sv */
// rcfr_checker: port-level assertions for the RC channel frame receiver.
// Depends on rcfr_pkg; bound to rc_channel_frame_receiver_top below.

module rcfr_checker import rcfr_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            out_valid,
    input logic            out_ready,
    input logic [CH_W-1:0] throttle,
    input logic            armed,
    input logic            failsafe,
    input logic            frame_accepted
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(throttle) && $stable(armed) &&
        $stable(failsafe) && $stable(frame_accepted))
        else $error("result payload changed while stalled");

    // Failsafe forces throttle and armed low
    a_failsafe_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && failsafe |-> (throttle == '0) && !armed)
        else $error("failsafe with live throttle or armed");

    // An accepted frame always leaves failsafe
    a_frame_no_fs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_accepted |-> !failsafe)
        else $error("frame accepted but failsafe still set");

endmodule

bind rc_channel_frame_receiver_top rcfr_checker u_rcfr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .throttle       (out_ch.throttle),
    .armed          (out_ch.armed),
    .failsafe       (out_ch.failsafe),
    .frame_accepted (out_ch.frame_accepted)
);
